// File: rtl/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

  localparam int PixW       = 8;
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgWidthW-1:0]  RstFrameWidth  = 11'd800;
  localparam logic [CfgHeightW-1:0] RstFrameHeight = 13'd600;

  typedef logic [PixW-1:0] pixel_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  // Control that travels alongside a neighborhood through the sorter.
  typedef struct packed {
    logic valid;
    logic last;
  } mf3_ctl_t;

endpackage

// File: rtl/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter.
//
// Usage: 8-bit grayscale pixels enter in raster order on the input channel
// (in_valid_i / in_ready_o, fields pixel_i and operation_i). Each transaction
// may produce one result on the output channel (out_valid_o / out_ready_i,
// fields filtered_o and last_of_frame_o). Borders are zero padded. Results
// lag the input by one row plus one pixel; after a frame the host sends
// frame_width+1 pad transactions (operation_i = 1) to flush the last row.
// Once accepted, a transaction's result passes through the line memory read,
// the window shift with the first sorter stage, two more sorter stages and
// the output register.
// Throughput is one transaction per cycle while the output is not stalled;
// the single read-modify-write of the line memory per pixel and the
// forwarding path keep that rate even for a one-pixel-wide frame.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is for the user to write
// while idle (the block does not enforce it): index 0 sets frame_width, index 1 frame_height.
// Reset clears the counters, the window and the output side and loads
// 800x600; the line memory is not cleared, its unwritten entries only feed
// masked border positions. When the receiver stalls, one more result lands
// in a skid register and then in_ready_o drops until the receiver takes the stalled result.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mf3_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mf3_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mf3_pkg::PixW-1:0]          pixel_i,
  input  logic                              operation_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mf3_pkg::PixW-1:0]          filtered_o,
  output logic                              last_of_frame_o
);

  localparam int PixW  = mf3_pkg::PixW;
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WCntW = $clog2(MAX_WIDTH + 1);
  localparam int HCntW = $clog2(MAX_HEIGHT + 1);
  localparam int RowW  = $clog2(MAX_HEIGHT + 3);
  localparam int MemW  = 2 * PixW;

  typedef struct packed {
    logic emit;
    logic case_a;     // row start: previous row's last pixel
    logic mask_left;
    logic mask_top;
    logic mask_bot;
    logic last;
  } item_info_t;

  // ---------------- configuration ----------------
  logic [mf3_pkg::CfgWidthW-1:0]  cfg_width_q;
  logic [mf3_pkg::CfgHeightW-1:0] cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= mf3_pkg::RstFrameWidth;
      cfg_height_q <= mf3_pkg::RstFrameHeight;
    end else if (cfg_we_i) begin
      case (mf3_pkg::cfg_index_e'(cfg_index_i))
        mf3_pkg::CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_data_i[mf3_pkg::CfgWidthW-1:0];
        mf3_pkg::CFG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[mf3_pkg::CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as 1, oversize saturates
  logic [WCntW-1:0] w_eff;
  logic [HCntW-1:0] h_eff;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WCntW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WCntW'(MAX_WIDTH);
    end else begin
      w_eff = WCntW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = HCntW'(1);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HCntW'(MAX_HEIGHT);
    end else begin
      h_eff = HCntW'(cfg_height_q);
    end
  end

  // ---------------- handshake / stall ----------------
  logic en;           // whole pipeline advances
  logic accept;
  logic skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // ---------------- input position (stage 0) ----------------
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  ic_a, ic;
  logic [RowW-1:0]  ir_a, ir;
  logic [RowW-1:0]  h_row, h_p1;
  logic [WCntW-1:0] col_inc;
  logic             wrap0, restart, ic_first;
  item_info_t       info_s0;
  logic [ColW-1:0]  col_d;
  logic [RowW-1:0]  row_d;

  always_comb begin
    h_row = RowW'(h_eff);
    h_p1  = h_row + RowW'(1);
    // width may have shrunk since the last transaction
    wrap0 = WCntW'(col_q) >= w_eff;
    ic_a  = wrap0 ? '0 : col_q;
    ir_a  = wrap0 ? row_q + RowW'(1) : row_q;
    restart = (ir_a > h_p1) || ((ir_a == h_p1) && (ic_a != '0));
    ic = restart ? '0 : ic_a;
    ir = restart ? '0 : ir_a;

    ic_first          = (ic == '0);
    info_s0.case_a    = ic_first && (ir >= RowW'(2));
    info_s0.emit      = info_s0.case_a ||
                        (!ic_first && (ir != '0) && (ir <= h_row));
    info_s0.last      = ic_first && (ir == h_p1);
    info_s0.mask_left = info_s0.case_a ? (w_eff == WCntW'(1)) : (ic == ColW'(1));
    info_s0.mask_top  = info_s0.case_a ? (ir == RowW'(2)) : (ir == RowW'(1));
    info_s0.mask_bot  = info_s0.case_a ? (ir == h_p1) : (ir == h_row);

    col_inc = WCntW'(ic) + WCntW'(1);
    if (info_s0.last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = ir + RowW'(1);
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = ir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: line memory read-modify-write ----------------
  logic            s1_valid_q;
  logic [ColW-1:0] s1_addr_q;
  mf3_pkg::pixel_t s1_pix_q;
  item_info_t      s1_info_q;
  logic            fwd_q;        // previous item wrote the entry this one read
  logic [MemW-1:0] fwd_data_q;
  logic [MemW-1:0] mem_rdata_q;
  logic [MemW-1:0] rd_word;
  logic [MemW-1:0] mem_wdata;
  logic            mem_we;
  mf3_pkg::pixel_t top, mid;

  // entry = {row two up, row above}
  logic [MemW-1:0] line_mem [MAX_WIDTH];

  assign rd_word   = fwd_q ? fwd_data_q : mem_rdata_q;
  assign top       = rd_word[MemW-1:PixW];
  assign mid       = rd_word[PixW-1:0];
  assign mem_wdata = {mid, s1_pix_q};
  assign mem_we    = s1_valid_q && en;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_addr_q] <= mem_wdata;
    end
    if (en) begin
      mem_rdata_q <= line_mem[ic];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= ic;
      s1_pix_q   <= operation_i ? '0 : pixel_i;   // pad items carry zero
      s1_info_q  <= info_s0;
      fwd_q      <= s1_valid_q && (s1_addr_q == ic);
      fwd_data_q <= mem_wdata;
    end
  end

  // ---------------- window and neighborhood ----------------
  mf3_pkg::pixel_t   win_q [9];
  mf3_pkg::pixel_t   new_col [3];
  mf3_pkg::pixel_t   nb [9];
  mf3_pkg::mf3_ctl_t med_ctl_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (mem_we) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
        win_q[r*3+2] <= new_col[r];
      end
    end
  end

  always_comb begin
    new_col[0] = top;
    new_col[1] = mid;
    new_col[2] = s1_pix_q;
    for (int r = 0; r < 3; r++) begin
      nb[r*3]   = win_q[r*3+1];
      nb[r*3+1] = win_q[r*3+2];
      // at a row start the right column lies past the frame edge
      nb[r*3+2] = s1_info_q.case_a ? '0 : new_col[r];
      if (s1_info_q.mask_left) begin
        nb[r*3] = '0;
      end
    end
    if (s1_info_q.mask_top) begin
      nb[0] = '0;
      nb[1] = '0;
      nb[2] = '0;
    end
    if (s1_info_q.mask_bot) begin
      nb[6] = '0;
      nb[7] = '0;
      nb[8] = '0;
    end
    med_ctl_in.valid = s1_valid_q && s1_info_q.emit;
    med_ctl_in.last  = s1_info_q.last;
  end

  // ---------------- sorter ----------------
  mf3_pkg::mf3_ctl_t med_ctl;
  mf3_pkg::pixel_t   med_pix;

  mf3_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (med_ctl_in),
    .nb_i   (nb),
    .ctl_o  (med_ctl),
    .med_o  (med_pix)
  );

  // ---------------- output register and skid ----------------
  logic            out_valid_q;
  mf3_pkg::pixel_t out_pix_q, skid_pix_q;
  logic            out_last_q, skid_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (med_ctl.valid) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_pix_q  <= skid_pix_q;
        out_last_q <= skid_last_q;
      end
    end else if (med_ctl.valid) begin
      if (!out_valid_q || out_ready_i) begin
        out_pix_q  <= med_pix;
        out_last_q <= med_ctl.last;
      end else begin
        skid_pix_q  <= med_pix;
        skid_last_q <= med_ctl.last;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign filtered_o      = out_pix_q;
  assign last_of_frame_o = out_last_q;

endmodule

// File: rtl/mf3_median.sv
// Three-stage pipelined median of nine pixels (row sort, column reduce, final median).
module mf3_median (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  mf3_pkg::mf3_ctl_t   ctl_i,
  input  mf3_pkg::pixel_t     nb_i [9],
  output mf3_pkg::mf3_ctl_t   ctl_o,
  output mf3_pkg::pixel_t     med_o
);

  function automatic mf3_pkg::pixel_t min2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pixel_t max2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic mf3_pkg::pixel_t med3(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b,
                                           mf3_pkg::pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  mf3_pkg::mf3_ctl_t ctl_a_q, ctl_b_q, ctl_c_q;
  mf3_pkg::pixel_t   row_min_q [3];
  mf3_pkg::pixel_t   row_med_q [3];
  mf3_pkg::pixel_t   row_max_q [3];
  mf3_pkg::pixel_t   lo_q, md_q, hi_q;
  mf3_pkg::pixel_t   med_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage A: sort each row
      for (int r = 0; r < 3; r++) begin
        row_min_q[r] <= min2(min2(nb_i[r*3], nb_i[r*3+1]), nb_i[r*3+2]);
        row_med_q[r] <= med3(nb_i[r*3], nb_i[r*3+1], nb_i[r*3+2]);
        row_max_q[r] <= max2(max2(nb_i[r*3], nb_i[r*3+1]), nb_i[r*3+2]);
      end
      // stage B: largest min, median of medians, smallest max
      lo_q <= max2(max2(row_min_q[0], row_min_q[1]), row_min_q[2]);
      md_q <= med3(row_med_q[0], row_med_q[1], row_med_q[2]);
      hi_q <= min2(min2(row_max_q[0], row_max_q[1]), row_max_q[2]);
      // stage C
      med_q <= med3(lo_q, md_q, hi_q);
    end
  end

  assign ctl_o = ctl_c_q;
  assign med_o = med_q;

endmodule

// File: rtl/mf3_checker.sv
// Port-level checker for the 3x3 median filter, bound to the top level.
`include "assert_macros.svh"

module mf3_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [mf3_pkg::PixW-1:0]     filtered_o,
  input logic                         last_of_frame_o
);

  // a stalled transaction stays offered
  `MF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "output transaction dropped while stalled")

  // and keeps its payload
  `MF_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(filtered_o) && $stable(last_of_frame_o), "output payload changed while stalled")

  // input back-pressure only while a result is parked
  `MF_ASSERT_IMP(a_bp_has_result, clk_i, rst_ni, !in_ready_o, out_valid_o, "input stalled with no pending result")

  // one taken result frees the input side
  `MF_ASSERT_NXT(a_bp_release, clk_i, rst_ni, !in_ready_o && out_ready_i, in_ready_o, "input still stalled after output drained")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
